[hdl/sp2c_pkg.sv]
// ----------------------------------------------------------------------------
// sp2c_pkg
// Shared types and constants for the scrolled planar-to-chunky converter.
// ----------------------------------------------------------------------------
package sp2c_pkg;

   localparam int MAX_PLANES  = 8;
   localparam int PIXELS      = 8;
   localparam int BYTE_WIDTH  = 8;
   localparam int SHIFT_WIDTH = 4;
   localparam int COUNT_WIDTH = 4;
   localparam int CSR_WIDTH   = 4;
   localparam int INDEX_WIDTH = 2;

   // Only the bits a window can still reach after the next byte shifts in:
   // window tops out at bit 15 + 7 = 22, of which 8 bits are the new byte.
   localparam int HIST_WIDTH  = (1 << SHIFT_WIDTH) - 1;
   localparam int WIDE_WIDTH  = HIST_WIDTH + BYTE_WIDTH;

   typedef enum logic [INDEX_WIDTH-1:0] {
      CSR_PLANE_COUNT = 2'd0,
      CSR_EVEN_SHIFT  = 2'd1,
      CSR_ODD_SHIFT   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  clear_history;
      logic [BYTE_WIDTH-1:0] plane0_byte;
      logic [BYTE_WIDTH-1:0] plane1_byte;
      logic [BYTE_WIDTH-1:0] plane2_byte;
      logic [BYTE_WIDTH-1:0] plane3_byte;
      logic [BYTE_WIDTH-1:0] plane4_byte;
      logic [BYTE_WIDTH-1:0] plane5_byte;
      logic [BYTE_WIDTH-1:0] plane6_byte;
      logic [BYTE_WIDTH-1:0] plane7_byte;
   } req_word_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] pixel_0;
      logic [BYTE_WIDTH-1:0] pixel_1;
      logic [BYTE_WIDTH-1:0] pixel_2;
      logic [BYTE_WIDTH-1:0] pixel_3;
      logic [BYTE_WIDTH-1:0] pixel_4;
      logic [BYTE_WIDTH-1:0] pixel_5;
      logic [BYTE_WIDTH-1:0] pixel_6;
      logic [BYTE_WIDTH-1:0] pixel_7;
   } rsp_word_type;

endpackage

[hdl/sp2c_if.sv]
// ----------------------------------------------------------------------------
// sp2c request / response channels
// Valid/ready stream interfaces carrying one word per handshake.
// ----------------------------------------------------------------------------
interface sp2c_req_if;
   logic                  valid;
   logic                  ready;
   sp2c_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface sp2c_rsp_if;
   logic                  valid;
   logic                  ready;
   sp2c_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hdl/scrolled_planar_to_chunky_top.sv]
// ----------------------------------------------------------------------------
// scrolled_planar_to_chunky_top
// Scrolled planar-to-chunky converter: per-plane byte history, scroll window
// select and 8x8 bit transpose into eight chunky pixels.
// ----------------------------------------------------------------------------
// Path: an accepted req word loads the input register, then passes to the
//   result register when it is empty or being drained; rsp is then valid.
// Throughput: 1 word per cycle unless rsp.ready stalls; the history update
//   loops on the plane history registers only, so words stream at full rate.
// Reset (synchronous, active high): histories zero, plane_count 8, both
//   scroll delays 0, both pipeline stages empty.
module scrolled_planar_to_chunky_top (
   input  logic                              clock,
   input  logic                              reset,
   sp2c_req_if.sink                          req,
   sp2c_rsp_if.source                        rsp,
   input  logic                              csr_write_enable,
   input  logic [sp2c_pkg::INDEX_WIDTH-1:0]  csr_index,
   input  logic [sp2c_pkg::CSR_WIDTH-1:0]    csr_write_data
);

   localparam int NP = sp2c_pkg::MAX_PLANES;
   localparam int BW = sp2c_pkg::BYTE_WIDTH;
   localparam int HW = sp2c_pkg::HIST_WIDTH;
   localparam int WW = sp2c_pkg::WIDE_WIDTH;

   // ---------------------------------------------------------------- config
   logic [sp2c_pkg::COUNT_WIDTH-1:0] plane_count_ff;
   logic [sp2c_pkg::SHIFT_WIDTH-1:0] even_shift_ff;
   logic [sp2c_pkg::SHIFT_WIDTH-1:0] odd_shift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_count_ff <= sp2c_pkg::COUNT_WIDTH'(NP);
         even_shift_ff  <= '0;
         odd_shift_ff   <= '0;
      end else if (csr_write_enable) begin
         case (sp2c_pkg::csr_index_type'(csr_index))
            sp2c_pkg::CSR_PLANE_COUNT: plane_count_ff <= csr_write_data;
            sp2c_pkg::CSR_EVEN_SHIFT:  even_shift_ff  <= csr_write_data;
            sp2c_pkg::CSR_ODD_SHIFT:   odd_shift_ff   <= csr_write_data;
            default: ;  // writes past the register list are dropped
         endcase
      end
   end

   // Counts above the plane limit behave as the limit.
   logic [sp2c_pkg::COUNT_WIDTH-1:0] active_count;
   assign active_count = (plane_count_ff > sp2c_pkg::COUNT_WIDTH'(NP))
                         ? sp2c_pkg::COUNT_WIDTH'(NP) : plane_count_ff;

   // ------------------------------------------------------- pipeline control
   // Stage 1 is the input register, stage 2 the result register. Stage 1
   // hands over when the result register is empty or being drained.
   logic                   s1_valid_ff;
   sp2c_pkg::req_word_type s1_data_ff;
   logic                   rsp_valid_ff;
   sp2c_pkg::rsp_word_type rsp_data_ff;
   logic                   out_free;
   logic                   s1_move;
   logic                   req_take;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign s1_move   = s1_valid_ff && out_free;
   assign req.ready = !s1_valid_ff || out_free;
   assign req_take  = req.valid && req.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req.ready) begin
         s1_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_data_ff <= req.data;
      end
   end

   // --------------------------------------------------------- plane datapath
   logic [NP-1:0][BW-1:0] plane_bytes;
   logic [NP-1:0][HW-1:0] hist_ff;
   logic [NP-1:0][HW-1:0] hist_in;
   logic [NP-1:0][BW-1:0] window;
   sp2c_pkg::rsp_word_type rsp_data_in;

   assign plane_bytes[0] = s1_data_ff.plane0_byte;
   assign plane_bytes[1] = s1_data_ff.plane1_byte;
   assign plane_bytes[2] = s1_data_ff.plane2_byte;
   assign plane_bytes[3] = s1_data_ff.plane3_byte;
   assign plane_bytes[4] = s1_data_ff.plane4_byte;
   assign plane_bytes[5] = s1_data_ff.plane5_byte;
   assign plane_bytes[6] = s1_data_ff.plane6_byte;
   assign plane_bytes[7] = s1_data_ff.plane7_byte;

   // Clear empties every plane, then active planes shift in their byte.
   // Inactive planes keep (possibly cleared) history and give a zero window.
   always_comb begin
      logic [HW-1:0]                    base;
      logic [WW-1:0]                    wide;
      logic [sp2c_pkg::SHIFT_WIDTH-1:0] sh;
      for (int p = 0; p < NP; p++) begin
         base = s1_data_ff.clear_history ? '0 : hist_ff[p];
         wide = {base, plane_bytes[p]};
         sh   = p[0] ? odd_shift_ff : even_shift_ff;
         if (sp2c_pkg::COUNT_WIDTH'(p) < active_count) begin
            hist_in[p] = wide[HW-1:0];
            window[p]  = BW'(wide >> sh);
         end else begin
            hist_in[p] = base;
            window[p]  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
      end else if (s1_move) begin
         hist_ff <= hist_in;
      end
   end

   // Transpose: pixel i bit p is window p bit (7 - i); pixel 0 is leftmost.
   always_comb begin
      logic [sp2c_pkg::PIXELS-1:0][BW-1:0] pix;
      for (int i = 0; i < sp2c_pkg::PIXELS; i++) begin
         for (int p = 0; p < NP; p++) begin
            pix[i][p] = window[p][BW-1-i];
         end
      end
      rsp_data_in.pixel_0 = pix[0];
      rsp_data_in.pixel_1 = pix[1];
      rsp_data_in.pixel_2 = pix[2];
      rsp_data_in.pixel_3 = pix[3];
      rsp_data_in.pixel_4 = pix[4];
      rsp_data_in.pixel_5 = pix[5];
      rsp_data_in.pixel_6 = pix[6];
      rsp_data_in.pixel_7 = pix[7];
   end

   // -------------------------------------------------------- result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.data  = rsp_data_ff;

   // ------------------------------------------------------------- assertions
   // History only moves when a word passes into the result register.
   a_hist_hold: assert property (@(posedge clock) disable iff (reset)
      !s1_move |=> $stable(hist_ff))
      else $error("plane history changed with no word moving");

   // A word leaving stage 1 always shows up as a valid result next cycle.
   a_move_lands: assert property (@(posedge clock) disable iff (reset)
      s1_move |=> rsp.valid)
      else $error("word from input register lost");

   // With no active planes every pixel of the result is zero.
   a_zero_planes: assert property (@(posedge clock) disable iff (reset)
      s1_move && (active_count == '0) |=> (rsp.data == '0))
      else $error("nonzero pixels with no active planes");

   // Stage 1 only accepts when it is empty or draining.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !out_free |-> !req_take)
      else $error("input register overwritten while stalled");

endmodule
